// ----- design/acf_pkg.sv -----
// Shared constants, types and the fractional root table of the frame compressor.
package acf_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int NCH_IO           = 8;
  localparam int CFG_W            = 16;
  localparam int LVL_W            = 16;
  localparam int MANT_W           = 31;
  localparam int SH_W             = 6;

  localparam logic signed [LVL_W-1:0] LEVEL_FLOOR = -16'sd23040;
  localparam logic signed [LVL_W-1:0] ENV_RESET   = -16'sd12800;
  localparam logic [SH_W-1:0]         SH_ZERO     = 6'd63;

  typedef enum logic [2:0] {
    REG_MONITOR   = 3'd0,
    REG_PROCESS   = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_THRESHOLD = 3'd4,
    REG_SLOPE     = 3'd5,
    REG_MAKEUP    = 3'd6
  } acf_reg_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic fin;
  } lane_ctl_t;

  typedef struct packed {
    logic [15:0]        att_coef;
    logic [15:0]        rel_coef;
    logic signed [15:0] threshold;
    logic [15:0]        slope;
    logic signed [13:0] makeup;
  } gain_cfg_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bv;
    rem = n;
    res = '0;
    bv  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bv > rem) begin
        bv = bv >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bv != 64'd0) begin
        if (rem >= res + bv) begin
          rem = rem - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
    end
    return res;
  endfunction

  // Root k is 2^(2^(7-k)/256) in Q30, each one the square root of the one before.
  function automatic logic [63:0] root_val(input int k);
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    for (int j = 1; j < 8; j++) begin
      if (j <= k) begin
        r = isqrt64(r << 30);
      end
    end
    return r;
  endfunction

  localparam logic [MANT_W-1:0] ROOT_TBL [8] = '{
    MANT_W'(root_val(0)), MANT_W'(root_val(1)), MANT_W'(root_val(2)),
    MANT_W'(root_val(3)), MANT_W'(root_val(4)), MANT_W'(root_val(5)),
    MANT_W'(root_val(6)), MANT_W'(root_val(7))
  };

endpackage

// ----- design/acf_lane.sv -----
// One channel lane: holds the sample, gives its detector share and applies the gain.
module acf_lane #(
  parameter int SAMPLE_BITS = acf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  acf_pkg::lane_ctl_t                ctl_i,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  input  logic                              monitor_i,
  input  logic                              process_i,
  input  logic [acf_pkg::MANT_W-1:0]        mant_i,
  input  logic [acf_pkg::SH_W-1:0]          shift_i,
  output logic signed [SAMPLE_BITS+2:0]     contrib_o,
  output logic [SAMPLE_BITS-1:0]            result_o
);
  import acf_pkg::*;

  localparam int PW = SAMPLE_BITS + MANT_W + 1;
  localparam int RW = 66;
  localparam logic signed [RW-1:0] MAXV = signed'((RW'(1) << (SAMPLE_BITS - 1)) - RW'(1));
  localparam logic signed [RW-1:0] MINV = -MAXV - signed'(RW'(1));

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [PW-1:0]          prod_q;
  logic [SAMPLE_BITS-1:0]        result_q;
  logic signed [RW-1:0]          rnd;
  logic signed [RW-1:0]          shifted;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      sample_q <= sample_i;
    end
    if (ctl_i.mul) begin
      prod_q <= sample_q * $signed({1'b0, mant_i});
    end
    if (ctl_i.fin) begin
      priority if (!process_i) begin
        result_q <= sample_q;
      end else if (shift_i == SH_ZERO) begin
        result_q <= '0;
      end else if (shifted > MAXV) begin
        result_q <= MAXV[SAMPLE_BITS-1:0];
      end else if (shifted < MINV) begin
        result_q <= MINV[SAMPLE_BITS-1:0];
      end else begin
        result_q <= shifted[SAMPLE_BITS-1:0];
      end
    end
  end

  always_comb begin
    rnd     = RW'(prod_q) + signed'(RW'(1) << (shift_i - SH_W'(1)));
    shifted = rnd >>> shift_i;
  end

  assign contrib_o = monitor_i ? (SAMPLE_BITS + 3)'(sample_q) : '0;
  assign result_o  = result_q;

endmodule

// ----- design/acf_merge.sv -----
// Registered adder tree that merges the lane shares into the detector magnitude.
module acf_merge #(
  parameter int SAMPLE_BITS = acf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic signed [SAMPLE_BITS+2:0] contrib_i [acf_pkg::NCH_IO],
  output logic [SAMPLE_BITS+2:0]        mag_o
);
  import acf_pkg::*;

  localparam int AW = SAMPLE_BITS + 3;

  logic signed [AW-1:0] lvl1_q [4];
  logic signed [AW-1:0] lvl2_q [2];
  logic signed [AW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      lvl1_q[i] <= contrib_i[2*i] + contrib_i[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      lvl2_q[i] <= lvl1_q[2*i] + lvl1_q[2*i+1];
    end
    sum_q <= lvl2_q[0] + lvl2_q[1];
  end

  assign mag_o = sum_q[AW-1] ? AW'(-sum_q) : AW'(sum_q);

endmodule

// ----- design/acf_log.sv -----
// Iterative log unit: normalizes the magnitude and squares out twelve bits of log2.
module acf_log #(
  parameter int SAMPLE_BITS = acf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [SAMPLE_BITS+2:0]           mag_i,
  output logic                             done_o,
  output logic signed [acf_pkg::LVL_W-1:0] level_o
);
  import acf_pkg::*;

  localparam int AW = SAMPLE_BITS + 3;
  localparam int CW = $clog2(AW + 1);
  localparam int TW = AW + 31;
  localparam logic signed [20:0] DB_K = 21'sd394566;

  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQR, L_MUL, L_FIN} log_state_e;

  log_state_e              state_q;
  logic [AW-1:0]           a_q;
  logic [CW-1:0]           sc_q;
  logic [30:0]             x_q;
  logic signed [19:0]      l_q;
  logic [3:0]              i_q;
  logic signed [39:0]      p_q;
  logic signed [LVL_W-1:0] level_q;
  logic                    done_q;

  logic [TW-1:0]           wide;
  logic [61:0]             sq;
  logic [31:0]             t;
  logic signed [19:0]      l_init;
  logic signed [39:0]      dbw;

  always_comb begin
    wide   = {a_q, 31'd0};
    sq     = x_q * x_q;
    t      = sq[61:30];
    l_init = 20'((AW - 1 - int'(sc_q) - (SAMPLE_BITS - 1)) * 4096);
    dbw    = (p_q + 40'sd1048576) >>> 21;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      a_q     <= '0;
      sc_q    <= '0;
      x_q     <= '0;
      l_q     <= '0;
      i_q     <= '0;
      p_q     <= '0;
      level_q <= LEVEL_FLOOR;
      done_q  <= 1'b0;
    end else begin
      done_q <= ((state_q == L_IDLE) && start_i && (mag_i == '0)) || (state_q == L_FIN);
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            if (mag_i == '0) begin
              level_q <= LEVEL_FLOOR;
            end else begin
              a_q     <= mag_i;
              sc_q    <= '0;
              state_q <= L_NORM;
            end
          end
        end
        L_NORM: begin
          priority if (a_q[AW-1]) begin
            x_q     <= wide[TW-1 -: 31];
            l_q     <= l_init;
            i_q     <= '0;
            state_q <= L_SQR;
          end else if (a_q[AW-1 -: 4] == 4'd0) begin
            a_q  <= a_q << 4;
            sc_q <= sc_q + CW'(4);
          end else begin
            a_q  <= a_q << 1;
            sc_q <= sc_q + CW'(1);
          end
        end
        L_SQR: begin
          if (t[31]) begin
            x_q <= t[31:1];
            l_q <= l_q + signed'(20'd2048 >> i_q);
          end else begin
            x_q <= t[30:0];
          end
          i_q <= i_q + 4'd1;
          if (i_q == 4'd11) begin
            state_q <= L_MUL;
          end
        end
        L_MUL: begin
          p_q     <= l_q * DB_K;
          state_q <= L_FIN;
        end
        L_FIN: begin
          if (dbw < 40'(LEVEL_FLOOR)) begin
            level_q <= LEVEL_FLOOR;
          end else begin
            level_q <= dbw[LVL_W-1:0];
          end
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign level_o = level_q;

endmodule

// ----- design/acf_gain.sv -----
// Envelope smoothing, gain computation and the iterative exp2 mantissa.
module acf_gain (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [acf_pkg::LVL_W-1:0] level_i,
  input  acf_pkg::gain_cfg_t               cfg_i,
  output logic                             done_o,
  output logic signed [acf_pkg::LVL_W-1:0] env_o,
  output logic [acf_pkg::MANT_W-1:0]       mant_o,
  output logic [acf_pkg::SH_W-1:0]         shift_o
);
  import acf_pkg::*;

  localparam logic signed [16:0] OCT_K = 17'sd21771;

  typedef enum logic [2:0] {
    G_IDLE, G_ENV1, G_ENV2, G_RED, G_RED2, G_EXP, G_FRAC, G_MANT
  } gain_state_e;

  gain_state_e             state_q;
  logic signed [LVL_W-1:0] env_q;
  logic signed [LVL_W-1:0] lvl_q;
  logic [15:0]             c_q;
  logic signed [32:0]      p_q;
  logic signed [33:0]      pr_q;
  logic signed [16:0]      g_q;
  logic signed [33:0]      pe_q;
  logic [7:0]              frac_q;
  logic [SH_W-1:0]         sh_q;
  logic [MANT_W-1:0]       mant_q;
  logic [2:0]              k_q;
  logic                    done_q;

  logic [16:0]             cw;
  logic signed [34:0]      acc;
  logic signed [34:0]      acc_sh;
  logic signed [16:0]      diff;
  logic signed [33:0]      red_w;
  logic signed [33:0]      e_w;
  logic signed [33:0]      ip_w;
  logic signed [33:0]      sh_w;
  logic [61:0]             mprod;
  logic [62:0]             msum;

  always_comb begin
    cw     = 17'd65536 - {1'b0, c_q};
    acc    = 35'(p_q) + $signed({1'b0, cw}) * lvl_q + 35'sd32768;
    acc_sh = acc >>> 16;
    diff   = 17'(env_q) - 17'(cfg_i.threshold);
    red_w  = (pr_q + 34'sd32768) >>> 16;
    e_w    = (pe_q + 34'sd32768) >>> 16;
    ip_w   = e_w >>> 8;
    sh_w   = 34'sd30 - ip_w;
    mprod  = mant_q * ROOT_TBL[k_q];
    msum   = 63'(mprod) + 63'(64'd1 << 29);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      env_q   <= ENV_RESET;
      lvl_q   <= '0;
      c_q     <= '0;
      p_q     <= '0;
      pr_q    <= '0;
      g_q     <= '0;
      pe_q    <= '0;
      frac_q  <= '0;
      sh_q    <= '0;
      mant_q  <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == G_MANT) && (k_q == 3'd7);
      unique case (state_q)
        G_IDLE: begin
          if (start_i) begin
            c_q     <= (level_i >= env_q) ? cfg_i.att_coef : cfg_i.rel_coef;
            lvl_q   <= level_i;
            state_q <= G_ENV1;
          end
        end
        G_ENV1: begin
          p_q     <= $signed({1'b0, c_q}) * env_q;
          state_q <= G_ENV2;
        end
        G_ENV2: begin
          env_q   <= acc_sh[LVL_W-1:0];
          state_q <= G_RED;
        end
        G_RED: begin
          if (env_q > cfg_i.threshold) begin
            pr_q <= diff * $signed({1'b0, cfg_i.slope});
          end else begin
            pr_q <= '0;
          end
          state_q <= G_RED2;
        end
        G_RED2: begin
          g_q     <= 17'(cfg_i.makeup) - 17'(red_w);
          state_q <= G_EXP;
        end
        G_EXP: begin
          pe_q    <= g_q * OCT_K;
          state_q <= G_FRAC;
        end
        G_FRAC: begin
          frac_q <= e_w[7:0];
          // Gains far below full scale collapse to a zero output.
          priority if (ip_w >= 34'sd30) begin
            sh_q <= SH_W'(1);
          end else if (sh_w >= 34'sd63) begin
            sh_q <= SH_ZERO;
          end else begin
            sh_q <= sh_w[SH_W-1:0];
          end
          mant_q  <= MANT_W'(64'd1 << 30);
          k_q     <= '0;
          state_q <= G_MANT;
        end
        G_MANT: begin
          if (frac_q[3'd7 - k_q]) begin
            mant_q <= msum[60:30];
          end
          k_q <= k_q + 3'd1;
          if (k_q == 3'd7) begin
            state_q <= G_IDLE;
          end
        end
        default: state_q <= G_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign env_o   = env_q;
  assign mant_o  = mant_q;
  assign shift_o = sh_q;

endmodule

// ----- design/audio_compressor_frame.sv -----
// Top level of the frame compressor: handshakes, configuration, lanes and sequencing.
//
// One frame of eight samples is taken per input transaction and one result transaction
// carries the eight processed samples with the smoothed detector level above them.
// From acceptance until its result is registered, a frame passes the lane adder tree,
// the log unit (normalization, twelve squaring iterations, the dB scaling, the clamp
// and the handover), the envelope and gain arithmetic with the eight iterations of the
// exp2 mantissa, and then the lanes and the output register. The normalization length
// depends on the magnitude of the monitored sum; a zero sum skips normalization and
// squaring and gives the floor level. With an empty monitor set a frame passes through
// and the envelope keeps its value. The block is ready for a new frame as soon as the
// previous result sits in the output register, even while that result is still waiting
// to be taken, but takes no frame while another is in progress; a finished frame waits
// in the output phase until the previous result has been taken.
// Configuration writes take effect at once and belong between frames.
module audio_compressor_frame #(
  parameter int NUM_CHANNELS = acf_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = acf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // sample_0 .. sample_7 from the lowest bits up
  input  logic [acf_pkg::NCH_IO*SAMPLE_BITS-1:0]    s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // out_0 .. out_7, then smoothed_level, from the lowest bits up
  output logic [acf_pkg::NCH_IO*SAMPLE_BITS+15:0]   m_axis_tdata,
  input  logic                                      cfg_we_i,
  input  logic [2:0]                                cfg_index_i,
  input  logic [acf_pkg::CFG_W-1:0]                 cfg_data_i
);
  import acf_pkg::*;

  localparam int AW    = SAMPLE_BITS + 3;
  localparam int OUT_W = NCH_IO * SAMPLE_BITS + LVL_W;
  localparam logic [NCH_IO-1:0] CH_MASK = NCH_IO'((1 << NUM_CHANNELS) - 1);

  typedef enum logic [2:0] {S_IDLE, S_SUM, S_LOG, S_GAIN, S_MUL, S_FIN, S_OUT} top_state_e;

  top_state_e          state_q;
  logic [1:0]          cnt_q;
  logic                m_valid_q;
  logic [OUT_W-1:0]    m_tdata_q;
  logic [OUT_W-1:0]    m_tdata_d;

  logic [7:0]          monitor_q;
  logic [7:0]          process_q;
  gain_cfg_t           gcfg_q;

  logic [NCH_IO-1:0]   mon;
  logic [NCH_IO-1:0]   proc_en;
  logic                apply;
  logic                in_acc;
  lane_ctl_t           lane_ctl;

  logic signed [AW-1:0]    contrib [NCH_IO];
  logic [SAMPLE_BITS-1:0]  lane_res [NCH_IO];
  logic [AW-1:0]           mag;
  logic                    log_start;
  logic                    log_done;
  logic signed [LVL_W-1:0] level;
  logic                    gain_start;
  logic                    gain_done;
  logic signed [LVL_W-1:0] env;
  logic [MANT_W-1:0]       mant;
  logic [SH_W-1:0]         shift;

  always_comb begin
    mon        = monitor_q & CH_MASK;
    apply      = |mon;
    proc_en    = process_q & CH_MASK & {NCH_IO{apply}};
    in_acc     = s_axis_tvalid && s_axis_tready;
    lane_ctl.load = in_acc;
    lane_ctl.mul  = (state_q == S_MUL);
    lane_ctl.fin  = (state_q == S_FIN);
    log_start  = (state_q == S_SUM) && (cnt_q == 2'd3) && apply;
    gain_start = (state_q == S_LOG) && log_done;
    for (int ch = 0; ch < NCH_IO; ch++) begin
      m_tdata_d[ch*SAMPLE_BITS +: SAMPLE_BITS] = lane_res[ch];
    end
    m_tdata_d[NCH_IO*SAMPLE_BITS +: LVL_W] = env;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      monitor_q        <= 8'd255;
      process_q        <= 8'd255;
      gcfg_q.att_coef  <= 16'd65000;
      gcfg_q.rel_coef  <= 16'd65500;
      gcfg_q.threshold <= -16'sd2560;
      gcfg_q.slope     <= 16'd32768;
      gcfg_q.makeup    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MONITOR:   monitor_q        <= cfg_data_i[7:0];
        REG_PROCESS:   process_q        <= cfg_data_i[7:0];
        REG_ATTACK:    gcfg_q.att_coef  <= cfg_data_i;
        REG_RELEASE:   gcfg_q.rel_coef  <= cfg_data_i;
        REG_THRESHOLD: gcfg_q.threshold <= cfg_data_i;
        REG_SLOPE:     gcfg_q.slope     <= cfg_data_i;
        REG_MAKEUP:    gcfg_q.makeup    <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      m_tdata_q <= '0;
    end else begin
      // In the output phase the register is either refilled or keeps its waiting result.
      if (m_valid_q && m_axis_tready && (state_q != S_OUT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cnt_q   <= '0;
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= apply ? S_LOG : S_MUL;
          end
        end
        S_LOG: begin
          if (log_done) begin
            state_q <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (gain_done) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_FIN;
        S_FIN: state_q <= S_OUT;
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_tdata_q <= m_tdata_d;
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;

  for (genvar ch = 0; ch < NCH_IO; ch++) begin : g_lane
    acf_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .ctl_i    (lane_ctl),
      .sample_i (s_axis_tdata[ch*SAMPLE_BITS +: SAMPLE_BITS]),
      .monitor_i(mon[ch]),
      .process_i(proc_en[ch]),
      .mant_i   (mant),
      .shift_i  (shift),
      .contrib_o(contrib[ch]),
      .result_o (lane_res[ch])
    );
  end

  acf_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk_i    (clk_i),
    .contrib_i(contrib),
    .mag_o    (mag)
  );

  acf_log #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(log_start),
    .mag_i  (mag),
    .done_o (log_done),
    .level_o(level)
  );

  acf_gain u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(gain_start),
    .level_i(level),
    .cfg_i  (gcfg_q),
    .done_o (gain_done),
    .env_o  (env),
    .mant_o (mant),
    .shift_o(shift)
  );

  a_log_done_in_log: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_done |-> (state_q == S_LOG))
    else $error("log unit finished outside the log phase");

  a_gain_done_in_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_done |-> (state_q == S_GAIN))
    else $error("gain unit finished outside the gain phase");

  a_env_only_in_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(env) |-> ($past(state_q) == S_GAIN))
    else $error("envelope changed outside the gain phase");

  a_accept_starts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_SUM))
    else $error("accepted frame did not start the adder tree phase");

endmodule
